### rtl/core/fllqb_pkg.sv
package fllqb_pkg;

  // operation codes
  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_PULL   = 1'b1;

  // one input item
  typedef struct packed {
    logic        op;
    logic [7:0]  msg_id;
    logic [15:0] msg_size;
  } fllqb_in_t;

  // one result item
  typedef struct packed {
    logic        accepted;
    logic        frag_valid;
    logic [7:0]  frag_msg_id;
    logic [6:0]  frag_seq;
    logic [6:0]  frag_total;
    logic [2:0]  frag_queue;
    logic [31:0] drop_count;
  } fllqb_out_t;

  // one stored fragment descriptor
  typedef struct packed {
    logic [7:0] id;
    logic [6:0] seq;
    logic [6:0] total;
  } frag_entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_COUNT,
    ST_PLACE,
    ST_PULL,
    ST_PULL_DATA,
    ST_RESP
  } fllqb_state_t;

endpackage

### rtl/core/fragmenting_least_loaded_queue_balancer_unit.sv
// Submit: check and decide states follow the input transfer, then the result when
// dropped or empty; a message of N fragments takes one count step per fragment, then
// one placement per fragment through the shared least-loaded compare unit. Pull: a
// pull state and a read of the single fragment store read port, skipped when every queue is empty.
// One item is in work at a time; in_ready is high only while the sequencer is idle.
// Synchronous reset clears occupancy, heads, round-robin pointer and drop counter;
// the fragment store is not cleared and needs no clearing pass.
module fragmenting_least_loaded_queue_balancer_unit
  import fllqb_pkg::*;
#(
  parameter int NUM_QUEUES     = 5,
  parameter int QUEUE_DEPTH    = 16,
  parameter int FRAGMENT_BYTES = 100
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fllqb_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output fllqb_out_t out_data
);

  localparam int Q_W       = $clog2(NUM_QUEUES);
  localparam int SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS     = NUM_QUEUES * QUEUE_DEPTH;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int FB_W      = $clog2(FRAGMENT_BYTES + 1);
  localparam int PROD_W    = CNT_W + FB_W;
  localparam int CMP_W     = (PROD_W > 16) ? PROD_W : 16;
  localparam int ADDR_W    = Q_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_QUEUES * (1 << SLOT_W);

  fllqb_state_t state_r, state_nxt;

  fllqb_in_t   req_r;
  logic [OCC_W-1:0]  occ_r  [NUM_QUEUES];
  logic [SLOT_W-1:0] head_r [NUM_QUEUES];
  logic [Q_W-1:0]    rr_r;
  logic [Q_W-1:0]    pull_q_r;
  logic [31:0]       drop_r;
  logic [CNT_W-1:0]  total_occ_r;
  logic [PROD_W-1:0] prod_r;
  logic [15:0]       rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  seq_r;
  fllqb_out_t        res_r;
  fllqb_out_t        out_r;
  logic              out_valid_r;
  frag_entry_t       rd_data_r;

  frag_entry_t mem [MEM_DEPTH];

  logic [OCC_W-1:0]  best_load;
  logic [SLOT_W-1:0] best_head;
  logic [Q_W-1:0]    best_q;
  logic [OCC_W:0]    slot_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [NUM_QUEUES-1:0] nonempty;
  logic [Q_W-1:0]    pull_q;
  logic [SLOT_W-1:0] pull_head;
  logic              pull_found;
  logic [Q_W-1:0]    rr_next;
  logic [CNT_W-1:0]  free_slots;
  logic              size_fits;
  logic              last_chunk;
  logic              last_frag;
  logic              out_free;
  logic              out_load;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  frag_entry_t       wr_entry;

  // least-loaded queue, ties to the lowest index
  always_comb begin
    best_load = OCC_W'(QUEUE_DEPTH);
    best_head = '0;
    best_q    = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (occ_r[i] < best_load) begin
        best_load = occ_r[i];
        best_head = head_r[i];
        best_q    = Q_W'(i);
      end
    end
  end

  // tail slot of the chosen queue
  always_comb begin
    slot_sum = (OCC_W+1)'(best_head) + (OCC_W+1)'(best_load);
    if (slot_sum >= (OCC_W+1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (OCC_W+1)'(QUEUE_DEPTH);
    end
    wr_slot = slot_sum[SLOT_W-1:0];
  end

  // round-robin search for the first non-empty queue
  always_comb begin
    logic [Q_W:0] idx;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      nonempty[i] = (occ_r[i] != '0);
    end
    pull_q     = '0;
    pull_found = 1'b0;
    for (int k = 0; k < NUM_QUEUES; k++) begin
      idx = (Q_W+1)'(rr_r) + (Q_W+1)'(k);
      if (idx >= (Q_W+1)'(NUM_QUEUES)) begin
        idx = idx - (Q_W+1)'(NUM_QUEUES);
      end
      if (!pull_found && nonempty[idx[Q_W-1:0]]) begin
        pull_q     = idx[Q_W-1:0];
        pull_found = 1'b1;
      end
    end
    pull_head = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (Q_W'(i) == pull_q) begin
        pull_head = head_r[i];
      end
    end
    rr_next = (pull_q == Q_W'(NUM_QUEUES - 1)) ? '0 : pull_q + 1'b1;
  end

  // free space check and fragment counting
  assign free_slots = CNT_W'(SLOTS) - total_occ_r;
  assign size_fits  = CMP_W'(req_r.msg_size) <= CMP_W'(prod_r);
  assign last_chunk = {1'b0, rem_r} <= 17'(FRAGMENT_BYTES);
  assign last_frag  = (seq_r + 1'b1) == cnt_r;
  assign out_free   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.op == OP_PULL) ? ST_PULL : ST_CHECK;
        end
      end
      ST_CHECK:  state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!size_fits || req_r.msg_size == 16'd0) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT:     state_nxt = last_chunk ? ST_PLACE : ST_COUNT;
      ST_PLACE:     state_nxt = last_frag ? ST_RESP : ST_PLACE;
      ST_PULL:      state_nxt = pull_found ? ST_PULL_DATA : ST_RESP;
      ST_PULL_DATA: state_nxt = ST_RESP;
      ST_RESP:      state_nxt = out_free ? ST_IDLE : ST_RESP;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_PLACE: mem_we   = 1'b1;
      ST_RESP:  out_load = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign wr_addr        = {best_q, wr_slot};
  assign rd_addr        = {pull_q, pull_head};
  assign wr_entry.id    = req_r.msg_id;
  assign wr_entry.seq   = 7'(seq_r);
  assign wr_entry.total = 7'(cnt_r);

  // fragment store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rr_r        <= '0;
      drop_r      <= '0;
      total_occ_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        occ_r[i]  <= '0;
        head_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // drop on insufficient space
      if (state_r == ST_DECIDE && !size_fits) begin
        drop_r <= drop_r + 1'b1;
      end
      // place one fragment
      if (state_r == ST_PLACE) begin
        total_occ_r <= total_occ_r + 1'b1;
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (Q_W'(i) == best_q) begin
            occ_r[i] <= occ_r[i] + 1'b1;
          end
        end
      end
      // pop one fragment
      if (state_r == ST_PULL && pull_found) begin
        total_occ_r <= total_occ_r - 1'b1;
        rr_r        <= rr_next;
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (Q_W'(i) == pull_q) begin
            occ_r[i]  <= occ_r[i] - 1'b1;
            head_r[i] <= (head_r[i] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_r[i] + 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (out_load) begin
      out_r <= res_r;
    end
    case (state_r)
      ST_CHECK: begin
        prod_r <= PROD_W'(free_slots) * PROD_W'(FRAGMENT_BYTES);
      end
      ST_DECIDE: begin
        rem_r             <= req_r.msg_size;
        cnt_r             <= '0;
        res_r.accepted    <= size_fits;
        res_r.frag_valid  <= 1'b0;
        res_r.frag_msg_id <= '0;
        res_r.frag_seq    <= '0;
        res_r.frag_total  <= '0;
        res_r.frag_queue  <= '0;
        res_r.drop_count  <= size_fits ? drop_r : drop_r + 1'b1;
      end
      ST_COUNT: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= rem_r - 16'(FRAGMENT_BYTES);
        seq_r <= '0;
      end
      ST_PLACE: begin
        seq_r <= seq_r + 1'b1;
      end
      ST_PULL: begin
        pull_q_r          <= pull_q;
        res_r.accepted    <= 1'b0;
        res_r.frag_valid  <= 1'b0;
        res_r.frag_msg_id <= '0;
        res_r.frag_seq    <= '0;
        res_r.frag_total  <= '0;
        res_r.frag_queue  <= '0;
        res_r.drop_count  <= drop_r;
      end
      ST_PULL_DATA: begin
        res_r.frag_valid  <= 1'b1;
        res_r.frag_msg_id <= rd_data_r.id;
        res_r.frag_seq    <= rd_data_r.seq;
        res_r.frag_total  <= rd_data_r.total;
        res_r.frag_queue  <= 3'(pull_q_r);
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // occupancy total never exceeds the number of slots
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_occ_r <= CNT_W'(SLOTS))
    else $error("total occupancy above slot count");

  // drop counter moves by at most one per cycle
  a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r == $past(drop_r)) || (drop_r == $past(drop_r) + 32'd1))
    else $error("drop counter jumped");

  // an accepted submit result never carries a fragment
  a_submit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.frag_valid)
    else $error("submit result marked as fragment");

  // a pulled fragment names an existing queue
  a_queue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frag_valid |-> out_data.frag_queue < 3'(NUM_QUEUES))
    else $error("fragment queue index out of range");

endmodule
